// ----- rtl/lfa_pkg.sv -----
// lfa_pkg: shared types and constants for the 8x8 life automaton
// board size, command codes, row type and the control bundle of a row cell
// no dependencies
package lfa_pkg;

  localparam int GRID_SIZE = 8;                  // rows and columns of the board
  localparam int ROW_W     = GRID_SIZE;          // bits held by one row cell
  localparam int IDX_W     = $clog2(GRID_SIZE);  // row counter width

  localparam int CMD_W     = 2;
  localparam int RIDX_W    = 3;
  localparam int RBITS_W   = 8;
  localparam int ROUT_W    = 8;
  localparam int CFG_W     = 8;
  localparam int BEAT_W    = 16;                 // tdata width on both sides

  localparam logic [CFG_W-1:0] MAX_STAG_RESET = 8'd5;
  localparam logic [CFG_W-1:0] STAG_CNT_MAX   = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic shift;  // take the neighbor's row
    logic load;   // take the loaded row
  } cell_ctrl_t;

endpackage

// ----- rtl/lfa_cell.sv -----
// lfa_cell: one board row held in a register, one link of the row chain
// depends on lfa_pkg
module lfa_cell import lfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  row_t       shift_i,
  input  row_t       load_i,
  output row_t       row_o
);

  row_t row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = shift_i;
    end else if (ctrl_i.load) begin
      row_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

// ----- rtl/lfa_rule.sv -----
// lfa_rule: next generation of one row from the rows above, at and below it
// depends on lfa_pkg; cells beyond the edges count as dead
module lfa_rule import lfa_pkg::*; (
  input  row_t above_i,
  input  row_t mid_i,
  input  row_t below_i,
  output row_t next_o
);

  always_comb begin
    logic [3:0] n;
    logic       hi_a, hi_m, hi_b, lo_a, lo_m, lo_b;
    next_o = '0;
    for (int j = 0; j < ROW_W; j++) begin
      hi_a = (j + 1 < ROW_W) ? above_i[(j + 1) % ROW_W] : 1'b0;
      hi_m = (j + 1 < ROW_W) ? mid_i[(j + 1) % ROW_W]   : 1'b0;
      hi_b = (j + 1 < ROW_W) ? below_i[(j + 1) % ROW_W] : 1'b0;
      lo_a = (j > 0) ? above_i[(j + ROW_W - 1) % ROW_W] : 1'b0;
      lo_m = (j > 0) ? mid_i[(j + ROW_W - 1) % ROW_W]   : 1'b0;
      lo_b = (j > 0) ? below_i[(j + ROW_W - 1) % ROW_W] : 1'b0;
      n = 4'(hi_a) + 4'(above_i[j]) + 4'(lo_a) + 4'(hi_m) + 4'(lo_m)
        + 4'(hi_b) + 4'(below_i[j]) + 4'(lo_b);
      // birth on three, survival on two or three
      next_o[j] = (n == 4'd3) || (mid_i[j] && (n == 4'd2));
    end
  end

endmodule

// ----- rtl/life_automaton_8x8.sv -----
// life_automaton_8x8: bounded 8x8 life board on a chain of row cells
// depends on lfa_pkg, lfa_cell, lfa_rule
//
//  channel   dir   width  beat contents (lsb first)
//  s_axis    in    16     command[1:0], row_index[4:2], row_bits[12:5], zero[15:13]
//  m_axis    out   16     row_out[7:0], changed[8], stagnant[9], zero[15:10]
//  cfg       in    8      stag_limit, written when cfg_we_i is high
//
// load, read and the unused code give their result through the output register, and a
// new beat may follow in the very next cycle while the skid stage is not full
// a step sweeps all GRID_SIZE rows: the row chain rotates one row per cycle
// through the single rule unit, which sees the previous, current and next row
// reset clears the board, the counters and both output stages; stag_limit returns to 5
// an output register plus a skid stage let one result wait while the next beat
// is taken; the input stalls while a step runs or the skid stage is full
module life_automaton_8x8 import lfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BEAT_W-1:0] s_axis_tdata,   // command, row_index, row_bits
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BEAT_W-1:0] m_axis_tdata,   // row_out, changed, stagnant
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_e;

  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_SIZE - 1);

  state_e            state_q;
  logic [IDX_W-1:0]  step_cnt_q;
  row_t              prev_q;          // old copy of the row above the current one
  logic              diff_q;          // some row of this generation changed so far
  logic              last_changed_q;
  logic [CFG_W-1:0]  stag_cnt_q;
  logic [CFG_W-1:0]  max_stag_q;
  logic              out_valid_q;
  logic [BEAT_W-1:0] out_data_q;
  logic              skid_valid_q;
  logic [BEAT_W-1:0] skid_data_q;

  // input beat fields
  cmd_e               cmd;
  logic [RIDX_W-1:0]  row_index;
  logic [RBITS_W-1:0] row_bits;
  logic               in_acc;
  logic               idx_ok;
  row_t               load_row;
  row_t               rd_row;

  // row chain
  row_t       rows     [GRID_SIZE];
  row_t       shift_in [GRID_SIZE];
  cell_ctrl_t cell_ctrl[GRID_SIZE];
  row_t       below_row;
  row_t       new_row;
  logic       step_last;
  logic       changed_d;
  logic [CFG_W-1:0] stag_cnt_d;

  // result of this cycle
  logic              res_push;
  logic [ROUT_W-1:0] res_row;
  logic              res_changed;
  logic              res_stag;
  logic [BEAT_W-1:0] res_beat;
  logic              out_free;

  assign cmd       = cmd_e'(s_axis_tdata[1:0]);
  assign row_index = s_axis_tdata[4:2];
  assign row_bits  = s_axis_tdata[12:5];

  assign s_axis_tready = (state_q == ST_IDLE) && !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = int'(row_index) < GRID_SIZE;
  assign load_row      = row_t'(row_bits);   // masked or widened to the row size

  // read mux over the cells
  always_comb begin
    rd_row = '0;
    for (int k = 0; k < GRID_SIZE; k++) begin
      if (int'(row_index) == k) begin
        rd_row = rows[k];
      end
    end
  end

  // cell 0 always holds the row being updated; new rows enter at the far end
  assign step_last = (step_cnt_q == LAST_ROW);
  assign below_row = step_last ? '0 : rows[1];   // below the bottom row is dead

  lfa_rule u_rule (
    .above_i (prev_q),
    .mid_i   (rows[0]),
    .below_i (below_row),
    .next_o  (new_row)
  );

  assign changed_d  = diff_q || (new_row != rows[0]);
  assign stag_cnt_d = (!changed_d && (stag_cnt_q != STAG_CNT_MAX))
                    ? stag_cnt_q + 8'd1 : stag_cnt_q;

  for (genvar k = 0; k < GRID_SIZE; k++) begin : g_cell
    if (k == GRID_SIZE - 1) begin : g_tail
      assign shift_in[k] = new_row;
    end else begin : g_link
      assign shift_in[k] = rows[k + 1];
    end

    assign cell_ctrl[k].shift = (state_q == ST_STEP);
    assign cell_ctrl[k].load  = in_acc && (cmd == CMD_LOAD) && (int'(row_index) == k);

    lfa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[k]),
      .shift_i (shift_in[k]),
      .load_i  (load_row),
      .row_o   (rows[k])
    );
  end

  // result beat assembly
  always_comb begin
    res_push    = 1'b0;
    res_row     = '0;
    res_changed = last_changed_q;
    res_stag    = stag_cnt_q > max_stag_q;
    if (in_acc) begin
      case (cmd)
        CMD_LOAD: begin
          res_push = 1'b1;
          res_row  = idx_ok ? ROUT_W'(load_row) : '0;
          res_stag = 1'b0;   // count is cleared, zero never exceeds the limit
        end
        CMD_STEP: begin
          res_push = 1'b0;   // result comes at the end of the sweep
        end
        CMD_READ: begin
          res_push = 1'b1;
          res_row  = idx_ok ? ROUT_W'(rd_row) : '0;
        end
        default: begin
          res_push = 1'b1;   // unused code: no effect, flags only
        end
      endcase
    end
    if ((state_q == ST_STEP) && step_last) begin
      res_push    = 1'b1;
      res_changed = changed_d;
      res_stag    = stag_cnt_d > max_stag_q;
    end
  end

  assign res_beat = {{(BEAT_W - ROUT_W - 2){1'b0}}, res_stag, res_changed, res_row};
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_cnt_q     <= '0;
      prev_q         <= '0;
      diff_q         <= 1'b0;
      last_changed_q <= 1'b0;
      stag_cnt_q     <= '0;
      max_stag_q     <= MAX_STAG_RESET;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      skid_valid_q   <= 1'b0;
      skid_data_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_stag_q <= cfg_wdata_i;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd == CMD_STEP)) begin
            state_q    <= ST_STEP;
            step_cnt_q <= '0;
            prev_q     <= '0;   // above the top row is dead
            diff_q     <= 1'b0;
          end
        end
        ST_STEP: begin
          prev_q     <= rows[0];
          diff_q     <= changed_d;
          step_cnt_q <= step_cnt_q + IDX_W'(1);
          if (step_last) begin
            state_q        <= ST_IDLE;
            last_changed_q <= changed_d;
            stag_cnt_q     <= stag_cnt_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (in_acc && (cmd == CMD_LOAD)) begin
        stag_cnt_q <= '0;
      end

      // output register with skid stage behind it
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q <= 1'b1;
          out_data_q  <= skid_data_q;
          if (res_push) begin
            skid_data_q <= res_beat;
          end else begin
            skid_valid_q <= 1'b0;
          end
        end else begin
          out_valid_q <= res_push;
          if (res_push) begin
            out_data_q <= res_beat;
          end
        end
      end else if (res_push) begin
        skid_valid_q <= 1'b1;
        skid_data_q  <= res_beat;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/lfa_checker.sv -----
// lfa_checker: port-level checks on the life automaton, bound to its top level
// depends on lfa_pkg and life_automaton_8x8
module lfa_checker import lfa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [BEAT_W-1:0] s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [BEAT_W-1:0] m_axis_tdata
);

  // no result beat right out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result beat offered right after reset");

  // a step beat holds off further input while the row chain computes the generation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == CMD_STEP))
    |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a generation is being computed");

  // a beat taken while the output is stalled fills the skid stage or starts a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready)
    |=> !s_axis_tready)
    else $error("input ready although the skid stage should be busy");

  // stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind life_automaton_8x8 lfa_checker u_lfa_checker (.*);
